@@ src/wpf_pkg.sv @@
package wpf_pkg;

	// Table geometry
	localparam int WP_DEPTH = 256;
	localparam int WP_AW = $clog2(WP_DEPTH);
	localparam int WP_CW = $clog2(WP_DEPTH + 1);
	localparam int WP_DW = 64;

	// CORDIC iteration count (8..24)
	localparam int CORDIC_STEPS = 16;
	localparam int CS_W = $clog2(CORDIC_STEPS);
	localparam int ATAN_IW = 5;
	localparam int ATAN_W = 30;

	// Datapath widths
	localparam int POS_W = 32;
	localparam int DIFF_W = POS_W + 1;
	localparam int CX_W = 36;
	localparam int CZ_W = 33;
	localparam int ANG_W = 16;
	localparam int ANGR_W = CZ_W - 16;
	localparam int HERR_W = ANG_W + 2;
	localparam int MAG_W = 31;
	localparam int MACC_W = 64;
	localparam int GAIN_W = 16;
	localparam int DINT_W = 47;
	localparam int HINT_W = 32;
	localparam int DD_W = MAG_W + 1;
	localparam int DH_W = ANG_W + 1;
	localparam int MA_W = 18;
	localparam int MB_W = 49;
	localparam int PROD_W = MA_W + MB_W;
	localparam int LIN_W = 58;
	localparam int HSUM_W = 50;
	localparam int ANGV_W = HSUM_W - 5;
	localparam int VEL_W = 16;
	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	// Constants
	localparam logic signed [HERR_W-1:0] PI_Q13 = HERR_W'(25736);
	localparam logic signed [HERR_W-1:0] TWO_PI_Q13 = HERR_W'(51472);
	localparam logic signed [CZ_W-1:0] HALF_PI_Q29 = CZ_W'(843314857);
	localparam logic [29:0] INV_GAIN_Q30 = 30'd652032874;
	localparam logic signed [LIN_W-1:0] LIN_HI = LIN_W'(26214);
	localparam logic signed [LIN_W-1:0] LIN_LO = -LIN_W'(26214);
	localparam logic signed [ANGV_W-1:0] ANGV_HI = ANGV_W'(19661);
	localparam logic signed [ANGV_W-1:0] ANGV_LO = -ANGV_W'(19661);
	localparam logic [DINT_W-1:0] DINT_MAX = {DINT_W{1'b1}};
	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	// Register indexes
	typedef enum logic [CFG_AW-1:0] {
		CFG_KP_DIST = 3'd0,
		CFG_KI_DIST = 3'd1,
		CFG_KD_DIST = 3'd2,
		CFG_KP_HEAD = 3'd3,
		CFG_KI_HEAD = 3'd4,
		CFG_KD_HEAD = 3'd5,
		CFG_REACH   = 3'd6
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CORDIC,
		ST_MUL,
		ST_ACC,
		ST_UPD,
		ST_OUT
	} state_t;

	// Shared multiplier products, in issue order
	typedef enum logic [2:0] {
		MUL_MAG_LO,
		MUL_MAG_HI,
		MUL_KP_D,
		MUL_KI_D,
		MUL_KD_D,
		MUL_KP_H,
		MUL_KI_H,
		MUL_KD_H
	} mul_op_t;

	typedef struct packed {
		logic              req_type;
		logic              new_path;
		logic signed [31:0] waypoint_x;
		logic signed [31:0] waypoint_y;
		logic signed [31:0] pose_x;
		logic signed [31:0] pose_y;
		logic signed [15:0] pose_theta;
	} in_t;

	typedef struct packed {
		logic signed [15:0] linear_velocity;
		logic signed [15:0] angular_velocity;
		logic [30:0]        distance_error;
		logic signed [15:0] heading_error;
		logic [7:0]         waypoint_index;
	} out_t;

	typedef struct packed {
		logic                     start;
		logic signed [DIFF_W-1:0] dx;
		logic signed [DIFF_W-1:0] dy;
	} cordic_req_t;

	typedef struct packed {
		logic                   done;
		logic signed [CX_W-1:0] x;
		logic signed [CZ_W-1:0] z;
	} cordic_rsp_t;

	// atan(2^-i) in Q1.29
	function automatic logic [ATAN_W-1:0] atan_q29(input logic [ATAN_IW-1:0] i);
		logic [ATAN_W-1:0] v;
		unique case (i)
			5'd0: v = 30'd421657428;
			5'd1: v = 30'd248918915;
			5'd2: v = 30'd131521918;
			5'd3: v = 30'd66762579;
			5'd4: v = 30'd33510843;
			5'd5: v = 30'd16771758;
			5'd6: v = 30'd8387925;
			5'd7: v = 30'd4194219;
			5'd8: v = 30'd2097141;
			5'd9: v = 30'd1048575;
			5'd10: v = 30'd524288;
			5'd11: v = 30'd262144;
			5'd12: v = 30'd131072;
			5'd13: v = 30'd65536;
			5'd14: v = 30'd32768;
			5'd15: v = 30'd16384;
			5'd16: v = 30'd8192;
			5'd17: v = 30'd4096;
			5'd18: v = 30'd2048;
			5'd19: v = 30'd1024;
			5'd20: v = 30'd512;
			5'd21: v = 30'd256;
			5'd22: v = 30'd128;
			5'd23: v = 30'd64;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

@@ src/wpf_ram.sv @@
module wpf_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/wpf_cordic.sv @@
module wpf_cordic (
	input  logic                clk,
	input  logic                arst_n,
	input  wpf_pkg::cordic_req_t req,
	output wpf_pkg::cordic_rsp_t rsp
);

	logic                            busy_q;
	logic                            done_q;
	logic [wpf_pkg::CS_W-1:0]        cnt_q;
	logic signed [wpf_pkg::CX_W-1:0] x_q;
	logic signed [wpf_pkg::CX_W-1:0] y_q;
	logic signed [wpf_pkg::CZ_W-1:0] z_q;

	logic signed [wpf_pkg::CX_W-1:0] xe, ye, xs, ys;
	logic signed [wpf_pkg::CZ_W-1:0] at;

	// Operand extension and shifted terms of the current rotation
	always_comb begin
		xe = wpf_pkg::CX_W'(req.dx);
		ye = wpf_pkg::CX_W'(req.dy);
		xs = x_q >>> cnt_q;
		ys = y_q >>> cnt_q;
		at = wpf_pkg::CZ_W'(wpf_pkg::atan_q29(wpf_pkg::ATAN_IW'(cnt_q)));
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= '0;
				if (req.dx == '0 && req.dy == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wpf_pkg::CS_W'(wpf_pkg::CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Vector rotation datapath; left half plane folded in by +-pi/2 first
	always_ff @(posedge clk) begin
		if (req.start) begin
			if (req.dx == '0 && req.dy == '0) begin
				x_q <= '0;
				y_q <= '0;
				z_q <= '0;
			end else if (req.dx < 0) begin
				if (req.dy >= 0) begin
					x_q <= ye;
					y_q <= -xe;
					z_q <= wpf_pkg::HALF_PI_Q29;
				end else begin
					x_q <= -ye;
					y_q <= xe;
					z_q <= -wpf_pkg::HALF_PI_Q29;
				end
			end else begin
				x_q <= xe;
				y_q <= ye;
				z_q <= '0;
			end
		end else if (busy_q) begin
			if (y_q < 0) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.x = x_q;
	assign rsp.z = z_q;

endmodule

@@ src/waypoint_pid_follower_top.sv @@
// Waypoint follower with two PID channels. A load transaction appends a
// waypoint to a 256-entry table (new_path restarts the path at index 0; a
// load to a full table is dropped) and leaves the block idle. A tick with a
// loaded path yields one result, and no new transaction is taken until its
// steps are done: one table read, the iterative CORDIC (one rotation per
// cycle over CORDIC_STEPS iterations plus the capture; no rotations when
// the target sits at the pose), eight products on a single shared 18x49
// multiplier, each a multiply and an accumulate step, one state update and
// one output step. A result still waiting in the output register holds the
// output step until it is taken. Ticks with an empty table give no result.
// Configuration writes are always accepted and must only be made while the
// block is idle. A finished result waits in the output register while the
// next transaction is accepted.
module waypoint_pid_follower_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  wpf_pkg::in_t                 in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output wpf_pkg::out_t                out_data,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [wpf_pkg::CFG_AW-1:0]   cfg_index,
	input  logic [wpf_pkg::CFG_DW-1:0]   cfg_data
);

	// Configuration registers
	logic [wpf_pkg::GAIN_W-1:0] kp_d_q, ki_d_q, kd_d_q, kp_h_q, ki_h_q, kd_h_q;
	logic [wpf_pkg::MAG_W-1:0]  reach_q;

	// Controller state
	wpf_pkg::state_t  state_q, state_d;
	wpf_pkg::mul_op_t op_q;
	logic [wpf_pkg::WP_CW-1:0]  count_q;
	logic [wpf_pkg::WP_AW-1:0]  tgt_q;
	logic [wpf_pkg::DINT_W-1:0] dint_q;
	logic signed [wpf_pkg::HINT_W-1:0] hint_q;
	logic [wpf_pkg::MAG_W-1:0]  last_d_q;
	logic signed [wpf_pkg::ANG_W-1:0] last_h_q;
	logic out_valid_q;
	wpf_pkg::out_t out_q;

	// Per-tick working registers
	logic signed [wpf_pkg::POS_W-1:0]  pose_x_q, pose_y_q;
	logic signed [wpf_pkg::ANG_W-1:0]  theta_q;
	logic signed [wpf_pkg::CX_W-1:0]   cx_q;
	logic signed [wpf_pkg::ANGR_W-1:0] ang_q;
	logic [wpf_pkg::MACC_W-1:0]        macc_q;
	logic [wpf_pkg::MAG_W-1:0]         mag_q;
	logic signed [wpf_pkg::ANG_W-1:0]  herr_q;
	logic signed [wpf_pkg::DD_W-1:0]   dd_q;
	logic signed [wpf_pkg::DH_W-1:0]   dh_q;
	logic signed [wpf_pkg::LIN_W-1:0]  lin_q;
	logic signed [wpf_pkg::HSUM_W-1:0] hsum_q;
	logic signed [wpf_pkg::PROD_W-1:0] prod_s1;

	logic in_acc, is_load, is_tick;
	logic ram_we;
	logic [wpf_pkg::WP_AW-1:0] ram_waddr, tgt_eff;
	logic [wpf_pkg::WP_DW-1:0] ram_rdata;
	wpf_pkg::cordic_req_t creq;
	wpf_pkg::cordic_rsp_t crsp;
	logic out_free;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && in_ready;
	assign is_load = in_acc && !in_data.req_type;
	assign is_tick = in_acc && in_data.req_type && (count_q != '0);
	assign out_free = !out_valid_q || out_ready;

	// Clamp a stale target index into the table
	always_comb begin
		if ({1'b0, tgt_q} >= count_q) begin
			tgt_eff = wpf_pkg::WP_AW'(count_q - 1'b1);
		end else begin
			tgt_eff = tgt_q;
		end
	end

	// Table write on load
	assign ram_we = is_load && (in_data.new_path || count_q < wpf_pkg::WP_CW'(wpf_pkg::WP_DEPTH));
	assign ram_waddr = in_data.new_path ? '0 : wpf_pkg::WP_AW'(count_q);

	wpf_ram #(
		.WIDTH(wpf_pkg::WP_DW),
		.DEPTH(wpf_pkg::WP_DEPTH)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata({in_data.waypoint_x, in_data.waypoint_y}),
		.raddr(tgt_eff),
		.rdata(ram_rdata)
	);

	// Vector from pose to target
	always_comb begin
		creq.start = (state_q == wpf_pkg::ST_READ);
		creq.dx = wpf_pkg::DIFF_W'($signed(ram_rdata[63:32])) - wpf_pkg::DIFF_W'(pose_x_q);
		creq.dy = wpf_pkg::DIFF_W'($signed(ram_rdata[31:0])) - wpf_pkg::DIFF_W'(pose_y_q);
	end

	wpf_cordic u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(creq),
		.rsp(crsp)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wpf_pkg::ST_IDLE: if (is_tick) state_d = wpf_pkg::ST_READ;
			wpf_pkg::ST_READ: state_d = wpf_pkg::ST_CORDIC;
			wpf_pkg::ST_CORDIC: if (crsp.done) state_d = wpf_pkg::ST_MUL;
			wpf_pkg::ST_MUL: state_d = wpf_pkg::ST_ACC;
			wpf_pkg::ST_ACC: begin
				if (op_q == wpf_pkg::MUL_MAG_HI) begin
					state_d = wpf_pkg::ST_UPD;
				end else if (op_q == wpf_pkg::MUL_KD_H) begin
					state_d = wpf_pkg::ST_OUT;
				end else begin
					state_d = wpf_pkg::ST_MUL;
				end
			end
			wpf_pkg::ST_UPD: state_d = wpf_pkg::ST_MUL;
			wpf_pkg::ST_OUT: if (out_free) state_d = wpf_pkg::ST_IDLE;
			default: state_d = wpf_pkg::ST_IDLE;
		endcase
	end

	// Handshake outputs
	always_comb begin
		in_ready = (state_q == wpf_pkg::ST_IDLE);
	end

	// Shared multiplier operand select
	logic signed [wpf_pkg::MA_W-1:0] ma;
	logic signed [wpf_pkg::MB_W-1:0] mb;
	always_comb begin
		unique case (op_q)
			wpf_pkg::MUL_MAG_LO: begin
				ma = $signed({1'b0, cx_q[16:0]});
				mb = $signed(wpf_pkg::MB_W'(wpf_pkg::INV_GAIN_Q30));
			end
			wpf_pkg::MUL_MAG_HI: begin
				ma = $signed({1'b0, cx_q[33:17]});
				mb = $signed(wpf_pkg::MB_W'(wpf_pkg::INV_GAIN_Q30));
			end
			wpf_pkg::MUL_KP_D: begin
				ma = $signed(wpf_pkg::MA_W'(kp_d_q));
				mb = $signed(wpf_pkg::MB_W'(mag_q));
			end
			wpf_pkg::MUL_KI_D: begin
				ma = $signed(wpf_pkg::MA_W'(ki_d_q));
				mb = $signed(wpf_pkg::MB_W'(dint_q));
			end
			wpf_pkg::MUL_KD_D: begin
				ma = $signed(wpf_pkg::MA_W'(kd_d_q));
				mb = wpf_pkg::MB_W'(dd_q);
			end
			wpf_pkg::MUL_KP_H: begin
				ma = $signed(wpf_pkg::MA_W'(kp_h_q));
				mb = wpf_pkg::MB_W'(herr_q);
			end
			wpf_pkg::MUL_KI_H: begin
				ma = $signed(wpf_pkg::MA_W'(ki_h_q));
				mb = wpf_pkg::MB_W'(hint_q);
			end
			wpf_pkg::MUL_KD_H: begin
				ma = $signed(wpf_pkg::MA_W'(kd_h_q));
				mb = wpf_pkg::MB_W'(dh_q);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Rounded distance term, Q8.8 gain scaling
	logic signed [wpf_pkg::PROD_W-1:0] prod_rnd, prod_sh;
	logic signed [wpf_pkg::LIN_W-1:0] lin_term;
	always_comb begin
		prod_rnd = prod_s1 + wpf_pkg::PROD_W'(128);
		prod_sh = prod_rnd >>> 8;
		lin_term = prod_sh[wpf_pkg::LIN_W-1:0];
	end

	// Magnitude, reach test, heading wrap and integrators
	logic [wpf_pkg::MACC_W:0] mag_rnd;
	logic [wpf_pkg::MAG_W-1:0] mag_v;
	logic reached;
	logic signed [wpf_pkg::HERR_W-1:0] herr0, herr_w;
	logic signed [wpf_pkg::ANG_W-1:0] herr_v;
	logic [wpf_pkg::DINT_W:0] dint_sum;
	logic signed [wpf_pkg::HINT_W:0] hint_sum;
	always_comb begin
		mag_rnd = {1'b0, macc_q} + (wpf_pkg::MACC_W + 1)'(64'd1 << 29);
		if (mag_rnd[wpf_pkg::MACC_W:30] > (wpf_pkg::MACC_W - 29)'(wpf_pkg::MAG_MAX)) begin
			mag_v = wpf_pkg::MAG_MAX;
		end else begin
			mag_v = mag_rnd[30 +: wpf_pkg::MAG_W];
		end
		reached = mag_v < reach_q;
		herr0 = wpf_pkg::HERR_W'(ang_q) - wpf_pkg::HERR_W'(theta_q);
		priority if (herr0 > wpf_pkg::PI_Q13) begin
			herr_w = herr0 - wpf_pkg::TWO_PI_Q13;
		end else if (herr0 < -wpf_pkg::PI_Q13) begin
			herr_w = herr0 + wpf_pkg::TWO_PI_Q13;
		end else begin
			herr_w = herr0;
		end
		herr_v = reached ? '0 : herr_w[wpf_pkg::ANG_W-1:0];
		dint_sum = {1'b0, dint_q} + (wpf_pkg::DINT_W + 1)'(mag_v);
		hint_sum = (wpf_pkg::HINT_W + 1)'(hint_q) + (wpf_pkg::HINT_W + 1)'(herr_v);
	end

	// Output rounding and clamps
	logic signed [wpf_pkg::HSUM_W-1:0] hsum_rnd;
	logic signed [wpf_pkg::ANGV_W-1:0] angv;
	logic signed [wpf_pkg::VEL_W-1:0] lin_o, ang_o;
	always_comb begin
		hsum_rnd = hsum_q + wpf_pkg::HSUM_W'(16);
		angv = wpf_pkg::ANGV_W'(hsum_rnd >>> 5);
		priority if (lin_q > wpf_pkg::LIN_HI) begin
			lin_o = wpf_pkg::VEL_W'(wpf_pkg::LIN_HI);
		end else if (lin_q < wpf_pkg::LIN_LO) begin
			lin_o = wpf_pkg::VEL_W'(wpf_pkg::LIN_LO);
		end else begin
			lin_o = lin_q[wpf_pkg::VEL_W-1:0];
		end
		priority if (angv > wpf_pkg::ANGV_HI) begin
			ang_o = wpf_pkg::VEL_W'(wpf_pkg::ANGV_HI);
		end else if (angv < wpf_pkg::ANGV_LO) begin
			ang_o = wpf_pkg::VEL_W'(wpf_pkg::ANGV_LO);
		end else begin
			ang_o = angv[wpf_pkg::VEL_W-1:0];
		end
	end

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kp_d_q <= 16'd128;
			ki_d_q <= '0;
			kd_d_q <= '0;
			kp_h_q <= 16'd512;
			ki_h_q <= '0;
			kd_h_q <= '0;
			reach_q <= 31'd6554;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wpf_pkg::CFG_KP_DIST: kp_d_q <= cfg_data[wpf_pkg::GAIN_W-1:0];
				wpf_pkg::CFG_KI_DIST: ki_d_q <= cfg_data[wpf_pkg::GAIN_W-1:0];
				wpf_pkg::CFG_KD_DIST: kd_d_q <= cfg_data[wpf_pkg::GAIN_W-1:0];
				wpf_pkg::CFG_KP_HEAD: kp_h_q <= cfg_data[wpf_pkg::GAIN_W-1:0];
				wpf_pkg::CFG_KI_HEAD: ki_h_q <= cfg_data[wpf_pkg::GAIN_W-1:0];
				wpf_pkg::CFG_KD_HEAD: kd_h_q <= cfg_data[wpf_pkg::GAIN_W-1:0];
				wpf_pkg::CFG_REACH: reach_q <= cfg_data[wpf_pkg::MAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Control state: path bookkeeping, PID state, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wpf_pkg::ST_IDLE;
			op_q <= wpf_pkg::MUL_MAG_LO;
			count_q <= '0;
			tgt_q <= '0;
			dint_q <= '0;
			hint_q <= '0;
			last_d_q <= '0;
			last_h_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// New result loads as the old one leaves, otherwise the taken one clears
			if (state_q == wpf_pkg::ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				wpf_pkg::ST_IDLE: begin
					op_q <= wpf_pkg::MUL_MAG_LO;
					if (is_load) begin
						if (in_data.new_path) begin
							count_q <= wpf_pkg::WP_CW'(1);
							tgt_q <= '0;
						end else if (count_q < wpf_pkg::WP_CW'(wpf_pkg::WP_DEPTH)) begin
							count_q <= count_q + 1'b1;
						end
					end else if (is_tick) begin
						tgt_q <= tgt_eff;
					end
				end
				wpf_pkg::ST_ACC: begin
					if (op_q != wpf_pkg::MUL_KD_H) begin
						op_q <= wpf_pkg::mul_op_t'(op_q + 3'd1);
					end
				end
				wpf_pkg::ST_UPD: begin
					if (reached && ({1'b0, tgt_q} + 1'b1) < count_q) begin
						tgt_q <= tgt_q + 1'b1;
					end
					dint_q <= dint_sum > {1'b0, wpf_pkg::DINT_MAX} ? wpf_pkg::DINT_MAX
						: dint_sum[wpf_pkg::DINT_W-1:0];
					priority if (hint_sum > (wpf_pkg::HINT_W + 1)'(32'sh7fffffff)) begin
						hint_q <= 32'sh7fffffff;
					end else if (hint_sum < -(wpf_pkg::HINT_W + 1)'(33'sh080000000)) begin
						hint_q <= 32'sh80000000;
					end else begin
						hint_q <= hint_sum[wpf_pkg::HINT_W-1:0];
					end
					last_d_q <= mag_v;
					last_h_q <= herr_v;
				end
				default: ;
			endcase
		end
	end

	// Per-tick datapath registers
	always_ff @(posedge clk) begin
		if (is_tick) begin
			pose_x_q <= in_data.pose_x;
			pose_y_q <= in_data.pose_y;
			theta_q <= in_data.pose_theta;
		end
		if (state_q == wpf_pkg::ST_CORDIC && crsp.done) begin
			cx_q <= crsp.x;
			ang_q <= wpf_pkg::ANGR_W'((crsp.z + wpf_pkg::CZ_W'(32768)) >>> 16);
		end
		if (state_q == wpf_pkg::ST_MUL) begin
			prod_s1 <= ma * mb;
		end
		if (state_q == wpf_pkg::ST_UPD) begin
			mag_q <= mag_v;
			herr_q <= herr_v;
			dd_q <= $signed({1'b0, mag_v}) - $signed({1'b0, last_d_q});
			dh_q <= wpf_pkg::DH_W'(herr_v) - wpf_pkg::DH_W'(last_h_q);
		end
		if (state_q == wpf_pkg::ST_ACC) begin
			unique case (op_q)
				wpf_pkg::MUL_MAG_LO: macc_q <= wpf_pkg::MACC_W'(prod_s1);
				wpf_pkg::MUL_MAG_HI: macc_q <= macc_q + {prod_s1[46:0], 17'd0};
				wpf_pkg::MUL_KP_D: lin_q <= lin_term;
				wpf_pkg::MUL_KI_D: lin_q <= lin_q + lin_term;
				wpf_pkg::MUL_KD_D: lin_q <= lin_q + lin_term;
				wpf_pkg::MUL_KP_H: hsum_q <= wpf_pkg::HSUM_W'(prod_s1);
				wpf_pkg::MUL_KI_H: hsum_q <= hsum_q + wpf_pkg::HSUM_W'(prod_s1);
				wpf_pkg::MUL_KD_H: hsum_q <= hsum_q + wpf_pkg::HSUM_W'(prod_s1);
				default: ;
			endcase
		end
		if (state_q == wpf_pkg::ST_OUT && out_free) begin
			out_q.linear_velocity <= lin_o;
			out_q.angular_velocity <= ang_o;
			out_q.distance_error <= mag_q;
			out_q.heading_error <= herr_q;
			out_q.waypoint_index <= 8'(tgt_q);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

@@ src/wpf_checker.sv @@
module wpf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input wpf_pkg::out_t              out_data
);

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Velocity commands stay within their clamps
	a_vel_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.linear_velocity <= 16'sd26214
			&& out_data.linear_velocity >= -16'sd26214
			&& out_data.angular_velocity <= 16'sd19661
			&& out_data.angular_velocity >= -16'sd19661)
		else $error("velocity outside clamp");

	// Heading error is wrapped into plus or minus pi
	a_head_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.heading_error <= 16'sd25736
			&& out_data.heading_error >= -16'sd25736)
		else $error("heading error not wrapped");

	// No new result can appear in the cycle after a transaction is taken
	a_no_instant: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && !out_valid |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind waypoint_pid_follower_top wpf_checker u_wpf_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_ready(in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data(out_data)
);
